### sv/rac_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and sequencer states of the region access checker.
package rac_pkg;

  localparam int unsigned RegionSlots = 256;
  localparam int unsigned IdxW = (RegionSlots > 1) ? $clog2(RegionSlots) : 1;
  localparam int unsigned CntW = $clog2(RegionSlots + 1);
  localparam logic [CntW-1:0] SlotsLimit = CntW'(RegionSlots);

  localparam logic [15:0] DomainMaskReset = 16'hDFBF;

  localparam logic [1:0] ModeAdd   = 2'd0;
  localparam logic [1:0] ModeCheck = 2'd1;
  localparam logic [1:0] ModeClear = 2'd2;

  localparam logic RegDomainMask = 1'b0;

  typedef enum logic [2:0] {
    StIdle,
    StAdd,
    StScan,
    StHit,
    StClear,
    StFinish
  } rac_state_e;

  typedef struct packed {
    logic [3:0]  perms;
    logic [63:0] length;
    logic [63:0] base;
  } region_entry_t;

  typedef struct packed {
    logic [63:0] stamp;
    logic [31:0] hits;
  } region_stat_t;

endpackage

### sv/rac_ram.sv
`timescale 1ns / 1ps
// Generic single write port, single read port RAM with registered read data.
module rac_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/rac_range_unit.sv
`timescale 1ns / 1ps
// Shared range compare unit: tests whether an address lies inside one region.
module rac_range_unit (
  input  logic [63:0]           address_i,
  input  rac_pkg::region_entry_t entry_i,
  output logic                  match_o
);

  logic [64:0] diff;

  // The borrow out of the 65-bit difference flags an address below the base.
  assign diff    = {1'b0, address_i} - {1'b0, entry_i.base};
  assign match_o = !diff[64] && (diff[63:0] < entry_i.length);

endmodule

### sv/region_access_checker.sv
`timescale 1ns / 1ps
// Top level of the region access checker with its sequencer and statistics.
//
//   Channel  Direction  Handshake                     Payload
//   in       input      in_valid_i / in_ready_o       mode .. now_time
//   out      output     out_valid_o / out_ready_i     granted .. keys_in_use
//   cfg      input      psel, penable, pwrite, pready domain_permission_mask
//
// A check walks through the region table, one entry per cycle through the table RAM read
// port and the range compare unit. A statistics clear walks the table the same way.
// One item is worked on at a time; the result register lets the next item start
// while a result still waits for its transfer. Reset empties the table and clears
// all counters; no clearing pass is needed.
module region_access_checker (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  mode_i,
  input  logic [63:0] address_i,
  input  logic [63:0] region_size_i,
  input  logic [3:0]  key_i,
  input  logic [3:0]  region_perms_i,
  input  logic [1:0]  requester_domain_i,
  input  logic [1:0]  access_kind_i,
  input  logic [63:0] now_time_i,

  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        granted_o,
  output logic        region_hit_o,
  output logic [7:0]  hit_index_o,
  output logic [31:0] hit_access_count_o,
  output logic [8:0]  regions_in_use_o,
  output logic [31:0] checks_total_o,
  output logic [31:0] denials_total_o,
  output logic [15:0] keys_in_use_o,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned IdxW = rac_pkg::IdxW;
  localparam int unsigned CntW = rac_pkg::CntW;

  rac_pkg::rac_state_e state_q, state_d;

  logic [1:0]  req_mode_q;
  logic [63:0] req_addr_q;
  logic [63:0] req_size_q;
  logic [3:0]  req_key_q;
  logic [3:0]  req_perms_q;
  logic [1:0]  req_dom_q;
  logic [1:0]  req_kind_q;
  logic [63:0] req_now_q;

  logic [CntW-1:0] ptr_q;
  logic            cmp_vld_q;
  logic [IdxW-1:0] cmp_idx_q;

  logic [CntW-1:0] count_q;
  logic [31:0]     checks_q;
  logic [31:0]     denials_q;
  logic [15:0]     keys_q;
  logic [15:0]     dom_mask_q;

  logic [3:0]      hit_perms_q;
  logic [31:0]     hit_cnt_q;
  logic            res_granted_q;
  logic            res_hit_q;
  logic [IdxW-1:0] res_idx_q;
  logic [31:0]     res_cnt_q;

  logic        out_valid_q;
  logic        out_granted_q;
  logic        out_hit_q;
  logic [7:0]  out_idx_q;
  logic [31:0] out_cnt_q;
  logic [8:0]  out_regions_q;
  logic [31:0] out_checks_q;
  logic [31:0] out_denials_q;
  logic [15:0] out_keys_q;

  logic in_accept;
  logic out_free;
  logic issue;
  logic table_full;
  logic match;
  logic scan_hit;
  logic allow;
  logic cfg_write;

  logic                  tbl_we;
  rac_pkg::region_entry_t tbl_wdata;
  rac_pkg::region_entry_t tbl_rdata;
  logic                  rd_en;
  logic [IdxW-1:0]       rd_addr;
  logic                  stat_we;
  logic [IdxW-1:0]       stat_waddr;
  rac_pkg::region_stat_t stat_wdata;
  rac_pkg::region_stat_t stat_rdata;

  assign in_ready_o = (state_q == rac_pkg::StIdle);
  assign in_accept  = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign issue      = (ptr_q < count_q);
  assign table_full = (count_q == rac_pkg::SlotsLimit);
  assign scan_hit   = (state_q == rac_pkg::StScan) && cmp_vld_q && match;
  assign allow      = dom_mask_q[{req_dom_q, req_kind_q}] && hit_perms_q[req_kind_q];

  assign tbl_wdata = '{perms: req_perms_q, length: req_size_q, base: req_addr_q};
  assign rd_addr   = ptr_q[IdxW-1:0];

  rac_range_unit u_range (
    .address_i (req_addr_q),
    .entry_i   (tbl_rdata),
    .match_o   (match)
  );

  rac_ram #(
    .Width ($bits(rac_pkg::region_entry_t)),
    .Depth (rac_pkg::RegionSlots)
  ) u_table_ram (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (count_q[IdxW-1:0]),
    .wdata_i (tbl_wdata),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (tbl_rdata)
  );

  rac_ram #(
    .Width ($bits(rac_pkg::region_stat_t)),
    .Depth (rac_pkg::RegionSlots)
  ) u_stat_ram (
    .clk_i   (clk_i),
    .we_i    (stat_we),
    .waddr_i (stat_waddr),
    .wdata_i (stat_wdata),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (stat_rdata)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rac_pkg::StIdle: begin
        if (in_accept) begin
          unique case (mode_i)
            rac_pkg::ModeAdd:   state_d = rac_pkg::StAdd;
            rac_pkg::ModeCheck: state_d = (count_q == '0) ? rac_pkg::StFinish : rac_pkg::StScan;
            rac_pkg::ModeClear: state_d = rac_pkg::StClear;
            default:            state_d = rac_pkg::StFinish;
          endcase
        end
      end
      rac_pkg::StAdd: state_d = rac_pkg::StFinish;
      rac_pkg::StScan: begin
        if (scan_hit) begin
          state_d = rac_pkg::StHit;
        end else if (!issue) begin
          state_d = rac_pkg::StFinish;
        end
      end
      rac_pkg::StHit: state_d = rac_pkg::StFinish;
      rac_pkg::StClear: begin
        if (!issue && !cmp_vld_q) begin
          state_d = rac_pkg::StFinish;
        end
      end
      rac_pkg::StFinish: begin
        if (out_free) begin
          state_d = rac_pkg::StIdle;
        end
      end
      default: state_d = rac_pkg::StIdle;
    endcase
  end

  always_comb begin
    tbl_we     = 1'b0;
    rd_en      = 1'b0;
    stat_we    = 1'b0;
    stat_waddr = count_q[IdxW-1:0];
    stat_wdata = '{stamp: 64'd0, hits: 32'd0};
    unique case (state_q)
      rac_pkg::StAdd: begin
        tbl_we  = !table_full;
        stat_we = !table_full;
      end
      rac_pkg::StScan: begin
        rd_en = issue;
      end
      rac_pkg::StHit: begin
        stat_we    = allow;
        stat_waddr = res_idx_q;
        stat_wdata = '{stamp: req_now_q, hits: hit_cnt_q + 32'd1};
      end
      rac_pkg::StClear: begin
        rd_en      = issue;
        stat_we    = cmp_vld_q;
        stat_waddr = cmp_idx_q;
        stat_wdata = '{stamp: stat_rdata.stamp, hits: 32'd0};
      end
      default: begin
      end
    endcase
  end

  assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == rac_pkg::RegDomainMask);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rac_pkg::StIdle;
      ptr_q       <= '0;
      cmp_vld_q   <= 1'b0;
      count_q     <= '0;
      checks_q    <= '0;
      denials_q   <= '0;
      keys_q      <= '0;
      dom_mask_q  <= rac_pkg::DomainMaskReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_write) begin
        dom_mask_q <= pwdata[15:0];
      end
      if (in_accept) begin
        ptr_q     <= '0;
        cmp_vld_q <= 1'b0;
        if (mode_i == rac_pkg::ModeCheck) begin
          checks_q <= checks_q + 32'd1;
        end else if (mode_i == rac_pkg::ModeClear) begin
          checks_q  <= '0;
          denials_q <= '0;
        end
      end else if ((state_q == rac_pkg::StScan) || (state_q == rac_pkg::StClear)) begin
        cmp_vld_q <= issue;
        if (issue) begin
          ptr_q <= ptr_q + CntW'(1);
        end
      end else begin
        cmp_vld_q <= 1'b0;
      end
      if ((state_q == rac_pkg::StAdd) && !table_full) begin
        count_q <= count_q + CntW'(1);
        if (req_key_q != 4'd0) begin
          keys_q[req_key_q] <= 1'b1;
        end
      end
      if ((state_q == rac_pkg::StHit) && !allow) begin
        denials_q <= denials_q + 32'd1;
      end
      if ((state_q == rac_pkg::StFinish) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_mode_q    <= mode_i;
      req_addr_q    <= address_i;
      req_size_q    <= region_size_i;
      req_key_q     <= key_i;
      req_perms_q   <= region_perms_i;
      req_dom_q     <= requester_domain_i;
      req_kind_q    <= access_kind_i;
      req_now_q     <= now_time_i;
      res_granted_q <= (mode_i == rac_pkg::ModeCheck);
      res_hit_q     <= 1'b0;
      res_idx_q     <= '0;
      res_cnt_q     <= '0;
    end
    if (issue && ((state_q == rac_pkg::StScan) || (state_q == rac_pkg::StClear))) begin
      cmp_idx_q <= ptr_q[IdxW-1:0];
    end
    if ((state_q == rac_pkg::StAdd) && (req_mode_q == rac_pkg::ModeAdd)) begin
      res_granted_q <= !table_full;
    end
    if (scan_hit) begin
      res_hit_q   <= 1'b1;
      res_idx_q   <= cmp_idx_q;
      hit_perms_q <= tbl_rdata.perms;
      hit_cnt_q   <= stat_rdata.hits;
    end
    if (state_q == rac_pkg::StHit) begin
      res_granted_q <= allow;
      res_cnt_q     <= allow ? (hit_cnt_q + 32'd1) : hit_cnt_q;
    end
    if ((state_q == rac_pkg::StFinish) && out_free) begin
      out_granted_q <= res_granted_q;
      out_hit_q     <= res_hit_q;
      out_idx_q     <= 8'(res_idx_q);
      out_cnt_q     <= res_cnt_q;
      out_regions_q <= 9'(count_q);
      out_checks_q  <= checks_q;
      out_denials_q <= denials_q;
      out_keys_q    <= keys_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign granted_o          = out_granted_q;
  assign region_hit_o       = out_hit_q;
  assign hit_index_o        = out_idx_q;
  assign hit_access_count_o = out_cnt_q;
  assign regions_in_use_o   = out_regions_q;
  assign checks_total_o     = out_checks_q;
  assign denials_total_o    = out_denials_q;
  assign keys_in_use_o      = out_keys_q;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == rac_pkg::RegDomainMask) ? {16'd0, dom_mask_q} : 32'd0;

endmodule

### sv/rac_checker.sv
`timescale 1ns / 1ps
// Port level assertions for the region access checker and their bind.
module rac_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        granted_o,
  input logic        region_hit_o,
  input logic [7:0]  hit_index_o,
  input logic [31:0] hit_access_count_o,
  input logic [8:0]  regions_in_use_o
);

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("Input side stayed ready right after a transfer.");

  a_miss_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !region_hit_o |-> (hit_index_o == 8'd0) && (hit_access_count_o == 32'd0))
    else $error("A result without a region hit carries an index or a count.");

  a_regions_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (regions_in_use_o <= 9'd256))
    else $error("More regions reported than the table holds.");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(granted_o) &&
      $stable(hit_index_o) && $stable(hit_access_count_o))
    else $error("A stalled result changed before its transfer.");

endmodule

bind region_access_checker rac_checker u_rac_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_valid_i),
  .in_ready_o         (in_ready_o),
  .out_valid_o        (out_valid_o),
  .out_ready_i        (out_ready_i),
  .granted_o          (granted_o),
  .region_hit_o       (region_hit_o),
  .hit_index_o        (hit_index_o),
  .hit_access_count_o (hit_access_count_o),
  .regions_in_use_o   (regions_in_use_o)
);

### tb/region_access_checker_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the region access checker, with a region table mirror.
module region_access_checker_tb;

  localparam logic [1:0]  ModeIgnored = 2'd3;
  localparam logic [2:0]  MaskAddr    = {rac_pkg::RegDomainMask, 2'b00};
  localparam logic [63:0] AllOnes     = {64{1'b1}};
  localparam int unsigned StallLimit  = 3000;
  localparam int unsigned DrainCycles = 300;

  typedef struct {
    logic [1:0]  mode;
    logic [63:0] address;
    logic [63:0] region_size;
    logic [3:0]  key;
    logic [3:0]  perms;
    logic [1:0]  domain;
    logic [1:0]  kind;
    logic [63:0] now_time;
  } request_t;

  typedef struct {
    logic        granted;
    logic        region_hit;
    logic [7:0]  hit_index;
    logic [31:0] hit_access_count;
    logic [8:0]  regions_in_use;
    logic [31:0] checks_total;
    logic [31:0] denials_total;
    logic [15:0] keys_in_use;
  } verdict_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  mode_i;
  logic [63:0] address_i;
  logic [63:0] region_size_i;
  logic [3:0]  key_i;
  logic [3:0]  region_perms_i;
  logic [1:0]  requester_domain_i;
  logic [1:0]  access_kind_i;
  logic [63:0] now_time_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic        granted_o;
  logic        region_hit_o;
  logic [7:0]  hit_index_o;
  logic [31:0] hit_access_count_o;
  logic [8:0]  regions_in_use_o;
  logic [31:0] checks_total_o;
  logic [31:0] denials_total_o;
  logic [15:0] keys_in_use_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  logic [63:0] mirror_base  [rac_pkg::RegionSlots];
  logic [63:0] mirror_size  [rac_pkg::RegionSlots];
  logic [3:0]  mirror_perms [rac_pkg::RegionSlots];
  logic [31:0] mirror_hits  [rac_pkg::RegionSlots];
  int unsigned mirror_count;
  logic [31:0] mirror_checks;
  logic [31:0] mirror_denials;
  logic [15:0] mirror_keys;
  logic [15:0] mirror_domain_mask;

  verdict_t    pending_verdicts[$];
  int unsigned mismatch_count;
  int unsigned burst_left;
  int unsigned idle_cycles;

  region_access_checker u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .mode_i             (mode_i),
    .address_i          (address_i),
    .region_size_i      (region_size_i),
    .key_i              (key_i),
    .region_perms_i     (region_perms_i),
    .requester_domain_i (requester_domain_i),
    .access_kind_i      (access_kind_i),
    .now_time_i         (now_time_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .granted_o          (granted_o),
    .region_hit_o       (region_hit_o),
    .hit_index_o        (hit_index_o),
    .hit_access_count_o (hit_access_count_o),
    .regions_in_use_o   (regions_in_use_o),
    .checks_total_o     (checks_total_o),
    .denials_total_o    (denials_total_o),
    .keys_in_use_o      (keys_in_use_o),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic void compare_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  function automatic verdict_t predict_verdict(input request_t r);
    verdict_t    v;
    int unsigned i;
    bit          found;
    v = '{default: '0};
    i = 0;
    found = 1'b0;
    case (r.mode)
      rac_pkg::ModeAdd: begin
        if (mirror_count < rac_pkg::RegionSlots) begin
          mirror_base[mirror_count]  = r.address;
          mirror_size[mirror_count]  = r.region_size;
          mirror_perms[mirror_count] = r.perms;
          mirror_hits[mirror_count]  = '0;
          mirror_count++;
          if (r.key != 4'd0) mirror_keys[r.key] = 1'b1;
          v.granted = 1'b1;
        end
      end
      rac_pkg::ModeCheck: begin
        mirror_checks++;
        while (!found && i < mirror_count) begin
          if (r.address >= mirror_base[i] && (r.address - mirror_base[i]) < mirror_size[i]) begin
            found = 1'b1;
          end else begin
            i++;
          end
        end
        if (!found) begin
          v.granted = 1'b1;
        end else begin
          v.region_hit = 1'b1;
          v.hit_index = 8'(i);
          if (!mirror_domain_mask[{r.domain, r.kind}] || !mirror_perms[i][r.kind]) begin
            mirror_denials++;
          end else begin
            mirror_hits[i]++;
            v.granted = 1'b1;
          end
          v.hit_access_count = mirror_hits[i];
        end
      end
      rac_pkg::ModeClear: begin
        mirror_checks = '0;
        mirror_denials = '0;
        for (i = 0; i < mirror_count; i++) mirror_hits[i] = '0;
      end
      default: ;
    endcase
    v.regions_in_use = 9'(mirror_count);
    v.checks_total = mirror_checks;
    v.denials_total = mirror_denials;
    v.keys_in_use = mirror_keys;
    return v;
  endfunction

  function automatic request_t random_request(input int unsigned add_weight);
    request_t    r;
    int unsigned roll;
    int unsigned pick;
    r.address = {$urandom, $urandom};
    r.region_size = {$urandom, $urandom};
    r.key = 4'($urandom);
    r.perms = 4'($urandom);
    r.domain = 2'($urandom);
    r.kind = 2'($urandom);
    r.now_time = {$urandom, $urandom};
    roll = $urandom_range(99);
    if (roll < add_weight) r.mode = rac_pkg::ModeAdd;
    else if (roll < 96) r.mode = rac_pkg::ModeCheck;
    else if (roll < 99) r.mode = rac_pkg::ModeClear;
    else r.mode = ModeIgnored;
    if (r.mode == rac_pkg::ModeAdd) begin
      case ($urandom_range(5))
        0: r.region_size = 64'($urandom_range(1, 4096));
        1: r.address = AllOnes - 64'($urandom_range(4095));
        2: begin
          if (mirror_count != 0) begin
            pick = $urandom_range(mirror_count - 1);
            r.address = mirror_base[pick] + 64'($urandom_range(64));
            r.region_size = 64'($urandom_range(1, 256));
          end
        end
        3: r.region_size = 64'd0;
        4: begin
          r.address = 64'($urandom_range(1 << 20));
          r.region_size = 64'($urandom_range(1, 1 << 16));
        end
        default: ;
      endcase
    end else if (r.mode == rac_pkg::ModeCheck && mirror_count != 0) begin
      pick = $urandom_range(mirror_count - 1);
      roll = $urandom_range(9);
      if (roll < 6) begin
        r.address = mirror_base[pick] +
                    ((mirror_size[pick] == 64'd0) ? 64'd0 : r.address % mirror_size[pick]);
      end else if (roll == 6) begin
        r.address = mirror_base[pick] + mirror_size[pick];
      end else if (roll == 7) begin
        r.address = mirror_base[pick] - 64'd1;
      end else if (roll == 8) begin
        r.address = ($urandom_range(1) == 0) ? 64'd0 : AllOnes;
      end
    end
    return r;
  endfunction

  function automatic request_t make_add(input logic [63:0] base, input logic [63:0] size,
                                        input logic [3:0] key, input logic [3:0] perms);
    request_t r;
    r = random_request(0);
    r.mode = rac_pkg::ModeAdd;
    r.address = base;
    r.region_size = size;
    r.key = key;
    r.perms = perms;
    return r;
  endfunction

  function automatic request_t make_check(input logic [63:0] addr, input logic [1:0] domain,
                                          input logic [1:0] kind);
    request_t r;
    r = random_request(0);
    r.mode = rac_pkg::ModeCheck;
    r.address = addr;
    r.domain = domain;
    r.kind = kind;
    return r;
  endfunction

  task automatic send_item(input request_t r);
    int unsigned gap;
    @(negedge clk_i);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 16);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    mode_i <= r.mode;
    address_i <= r.address;
    region_size_i <= r.region_size;
    key_i <= r.key;
    region_perms_i <= r.perms;
    requester_domain_i <= r.domain;
    access_kind_i <= r.kind;
    now_time_i <= r.now_time;
    do @(posedge clk_i); while (!in_ready_o);
    pending_verdicts.push_back(predict_verdict(r));
  endtask

  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic apb_transfer(input logic write, input logic [31:0] wdata,
                              output logic [31:0] rdata);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= write;
    paddr <= MaskAddr;
    pwdata <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic write_mask(input logic [15:0] value);
    logic [31:0] readback;
    apb_transfer(1'b1, {16'd0, value}, readback);
    mirror_domain_mask = value;
    apb_transfer(1'b0, 32'd0, readback);
    compare_field("domain_permission_mask", {48'd0, mirror_domain_mask}, {32'd0, readback});
  endtask

  task automatic test_register_access();
    logic [31:0] readback;
    apb_transfer(1'b0, 32'd0, readback);
    compare_field("domain_permission_mask", {48'd0, rac_pkg::DomainMaskReset},
                  {32'd0, readback});
    write_mask(16'h0000);
    write_mask(16'hFFFF);
    write_mask(16'($urandom));
    write_mask(rac_pkg::DomainMaskReset);
  endtask

  task automatic test_directed_cases();
    request_t r;
    send_item(make_check(64'd0, 2'd0, 2'd0));
    r = make_check(64'd0, 2'd0, 2'd0);
    r.mode = ModeIgnored;
    send_item(r);
    r.mode = rac_pkg::ModeClear;
    send_item(r);
    send_item(make_add(64'd0, 64'h100, 4'd0, 4'b1111));
    send_item(make_add(AllOnes - 64'd15, AllOnes, 4'd15, 4'b0001));
    send_item(make_add(64'h1000, 64'd0, 4'd1, 4'b1111));
    send_item(make_add(64'h80, 64'h100, 4'd7, 4'b0010));
    send_item(make_check(64'h50, 2'd0, 2'd0));
    send_item(make_check(64'hFF, 2'd0, 2'd1));
    send_item(make_check(64'h100, 2'd0, 2'd1));
    send_item(make_check(64'h100, 2'd0, 2'd0));
    send_item(make_check(64'h1000, 2'd0, 2'd0));
    send_item(make_check(AllOnes, 2'd0, 2'd0));
    send_item(make_check(AllOnes - 64'd15, 2'd3, 2'd0));
    send_item(make_check(AllOnes - 64'd16, 2'd0, 2'd0));
    send_item(make_check(AllOnes, 2'd0, 2'd1));
    send_item(make_check(64'h10, 2'd1, 2'd2));
    send_item(make_check(64'h10, 2'd0, 2'd3));
    r.mode = ModeIgnored;
    send_item(r);
    r.mode = rac_pkg::ModeClear;
    send_item(r);
    send_item(make_check(64'h10, 2'd2, 2'd0));
    send_item(make_check(64'h180, 2'd0, 2'd0));
  endtask

  task automatic test_mixed_traffic(input logic [15:0] mask, input int unsigned items,
                                    input int unsigned add_weight);
    settle();
    write_mask(mask);
    repeat (items) send_item(random_request(add_weight));
  endtask

  task automatic test_table_fill();
    request_t r;
    settle();
    write_mask(16'($urandom));
    while (mirror_count < rac_pkg::RegionSlots) send_item(random_request(60));
    repeat (6) begin
      r = random_request(0);
      r.mode = rac_pkg::ModeAdd;
      send_item(r);
    end
  endtask

  initial begin : stall_pattern
    int unsigned span;
    int unsigned style;
    out_ready_i = 1'b0;
    forever begin
      style = $urandom_range(3);
      span = $urandom_range(4, 40);
      repeat (span) begin
        @(negedge clk_i);
        case (style)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= 1'($urandom_range(1));
          2: out_ready_i <= ($urandom_range(7) == 0);
          default: out_ready_i <= ~out_ready_i;
        endcase
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    verdict_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_verdicts.size() == 0) begin
        $display("%0t: result transfer with no item waiting, expected none, got granted 0x%0h",
                 $time, granted_o);
        mismatch_count++;
      end else begin
        want = pending_verdicts.pop_front();
        compare_field("granted", 64'(want.granted), 64'(granted_o));
        compare_field("region_hit", 64'(want.region_hit), 64'(region_hit_o));
        compare_field("hit_index", 64'(want.hit_index), 64'(hit_index_o));
        compare_field("hit_access_count", 64'(want.hit_access_count),
                      64'(hit_access_count_o));
        compare_field("regions_in_use", 64'(want.regions_in_use), 64'(regions_in_use_o));
        compare_field("checks_total", 64'(want.checks_total), 64'(checks_total_o));
        compare_field("denials_total", 64'(want.denials_total), 64'(denials_total_o));
        compare_field("keys_in_use", 64'(want.keys_in_use), 64'(keys_in_use_o));
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    mode_i = rac_pkg::ModeAdd;
    address_i = '0;
    region_size_i = '0;
    key_i = '0;
    region_perms_i = '0;
    requester_domain_i = '0;
    access_kind_i = '0;
    now_time_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    mirror_count = 0;
    mirror_checks = '0;
    mirror_denials = '0;
    mirror_keys = '0;
    mirror_domain_mask = rac_pkg::DomainMaskReset;
    mismatch_count = 0;
    burst_left = 0;
    idle_cycles = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_register_access();
    test_directed_cases();
    test_mixed_traffic(16'hFFFF, 150, 30);
    test_mixed_traffic(16'h0000, 150, 30);
    test_mixed_traffic(16'($urandom), 150, 30);
    test_table_fill();
    test_mixed_traffic(rac_pkg::DomainMaskReset, 150, 10);
    test_mixed_traffic(16'($urandom), 150, 10);

    settle();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0 && pending_verdicts.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
